// ----- rtl/core/pmd_pkg.sv -----
// ---------------------------------------------------------------------------
// pmd_pkg
// Shared types and codes for the priority message dispatcher.
// ---------------------------------------------------------------------------
package pmd_pkg;

  localparam int ID_W   = 6;
  localparam int REQ_W  = 16;
  localparam int PRIO_W = 8;
  localparam int STAT_W = 3;
  localparam int FUNC_W = 2;
  localparam int NID_W  = ID_W + 1;

  // widest id the id fields can carry
  localparam int ID_LIMIT = 63;

  typedef enum logic [FUNC_W-1:0] {
    FN_REGISTER = 2'd0,
    FN_POST     = 2'd1,
    FN_DISPATCH = 2'd2,
    FN_NONE     = 2'd3
  } func_t;

  localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STAT_W-1:0] ST_QFULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_QEMPTY  = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STAT_W-1:0] ST_AFULL   = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]   sender;
    logic [ID_W-1:0]   target;
    logic [REQ_W-1:0]  request;
    logic [PRIO_W-1:0] priority_lvl;
  } msg_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  reg_en;
    logic  post_en;
    logic  disp_en;
    func_t op;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic tbl_full;
  } dp_status_t;

endpackage

// ----- rtl/core/pmd_ctrl.sv -----
// ---------------------------------------------------------------------------
// pmd_ctrl
// Handshake controller: tracks the result register and issues one command
// per accepted request.
// ---------------------------------------------------------------------------
module pmd_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_func,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  pmd_pkg::dp_status_t    dp_status,
  output pmd_pkg::cmd_t          cmd
);
  import pmd_pkg::*;

  typedef enum logic {
    S_EMPTY,
    S_FULL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;
  func_t  op;

  // result register frees up in the same cycle it is taken
  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign out_valid = (state_r == S_FULL);
  assign accept    = in_valid && in_ready;
  assign op        = func_t'(in_func);

  always_comb begin
    cmd.load    = accept;
    cmd.op      = op;
    cmd.reg_en  = accept && (op == FN_REGISTER) && !dp_status.tbl_full;
    cmd.post_en = accept && (op == FN_POST) && !dp_status.q_full;
    cmd.disp_en = accept && (op == FN_DISPATCH) && !dp_status.q_empty;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_EMPTY: begin
        if (accept) state_nxt = S_FULL;
      end
      S_FULL: begin
        if (!accept && out_ready) state_nxt = S_EMPTY;
      end
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/pmd_datapath.sv -----
// ---------------------------------------------------------------------------
// pmd_datapath
// Sorted shift-register message queue, agent id counter and result register.
// ---------------------------------------------------------------------------
module pmd_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_AGENTS  = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pmd_pkg::cmd_t                cmd,
  output pmd_pkg::dp_status_t          dp_status,
  input  logic [pmd_pkg::ID_W-1:0]     in_sender_id,
  input  logic [pmd_pkg::ID_W-1:0]     in_target_id,
  input  logic [pmd_pkg::REQ_W-1:0]    in_request_id,
  input  logic [pmd_pkg::PRIO_W-1:0]   in_priority_req,
  output logic [pmd_pkg::STAT_W-1:0]   out_status,
  output logic [pmd_pkg::ID_W-1:0]     out_assigned_id,
  output logic [pmd_pkg::ID_W-1:0]     out_sender,
  output logic [pmd_pkg::ID_W-1:0]     out_target,
  output logic [pmd_pkg::REQ_W-1:0]    out_request,
  output logic [pmd_pkg::PRIO_W-1:0]   out_priority
);
  import pmd_pkg::*;

  localparam int CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int IdLimit  = (MAX_AGENTS < ID_LIMIT) ? MAX_AGENTS : ID_LIMIT;
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  msg_t             q_r   [QUEUE_DEPTH];
  msg_t             q_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ins;
  logic [CntW-1:0]  count_r;
  logic [CntW-1:0]  count_nxt;
  logic [NID_W-1:0] next_id_r;
  logic [NID_W-1:0] next_id_nxt;
  msg_t             new_msg;
  msg_t             head;
  logic             head_present;

  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]   assigned_r, assigned_nxt;
  msg_t              res_msg_r, res_msg_nxt;

  assign new_msg = '{sender: in_sender_id, target: in_target_id,
                     request: in_request_id, priority_lvl: in_priority_req};
  assign head    = q_r[0];

  assign dp_status.q_full   = (count_r == DepthC);
  assign dp_status.q_empty  = (count_r == '0);
  assign dp_status.tbl_full = (next_id_r > NID_W'(IdLimit));

  // ids are handed out in order, so present means 0 < id < next_id
  assign head_present = (head.target != '0) && ({1'b0, head.target} < next_id_r);

  // insert slot marks: cell holds nothing or something of higher value
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ins[i] = !((CntW'(i) < count_r) && (q_r[i].priority_lvl <= new_msg.priority_lvl));
    end
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      always_comb begin
        q_nxt[g] = q_r[g];
        if (cmd.post_en) begin
          if (g == 0) begin
            if (ins[0]) q_nxt[g] = new_msg;
          end else begin
            if (ins[g - ((g > 0) ? 1 : 0)]) q_nxt[g] = q_r[g - ((g > 0) ? 1 : 0)];
            else if (ins[g]) q_nxt[g] = new_msg;
          end
        end else if (cmd.disp_en) begin
          if (g < QUEUE_DEPTH - 1) q_nxt[g] = q_r[g + ((g < QUEUE_DEPTH - 1) ? 1 : 0)];
        end
      end

      always_ff @(posedge clk) begin
        q_r[g] <= q_nxt[g];
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.post_en) count_nxt = count_r + CntW'(1);
    else if (cmd.disp_en) count_nxt = count_r - CntW'(1);
    next_id_nxt = next_id_r;
    if (cmd.reg_en) next_id_nxt = next_id_r + NID_W'(1);
  end

  always_comb begin
    status_nxt   = ST_DONE;
    assigned_nxt = '0;
    res_msg_nxt  = '0;
    unique case (cmd.op)
      FN_REGISTER: begin
        if (dp_status.tbl_full) begin
          status_nxt = ST_AFULL;
        end else begin
          assigned_nxt = next_id_r[ID_W-1:0];
        end
      end
      FN_POST: begin
        if (dp_status.q_full) status_nxt = ST_QFULL;
      end
      FN_DISPATCH: begin
        if (dp_status.q_empty) begin
          status_nxt = ST_QEMPTY;
        end else begin
          res_msg_nxt = head;
          status_nxt  = head_present ? ST_DONE : ST_UNKNOWN;
        end
      end
      FN_NONE: status_nxt = ST_DONE;
      default: status_nxt = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      next_id_r <= NID_W'(1);
    end else begin
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r   <= status_nxt;
      assigned_r <= assigned_nxt;
      res_msg_r  <= res_msg_nxt;
    end
  end

  assign out_status      = status_r;
  assign out_assigned_id = assigned_r;
  assign out_sender      = res_msg_r.sender;
  assign out_target      = res_msg_r.target;
  assign out_request     = res_msg_r.request;
  assign out_priority    = res_msg_r.priority_lvl;

endmodule

// ----- rtl/core/priority_message_dispatcher.sv -----
// ---------------------------------------------------------------------------
// priority_message_dispatcher
// Agent registration plus a priority-ordered message queue with dispatch.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   func, sender, target, request, priority
//   out_     output     out_valid / out_ready status, assigned id, message fields
//
// one request per cycle while no result waits or out_ready is high: the whole
// operation finishes in the accept cycle through a combinational shift of sorted
// queue cells. the result register is loaded at accept and read the next cycle.
// a new request is taken while a result waits if out_ready is high that cycle.
// reset empties the queue and restarts agent ids at one; no clearing pass.
// ---------------------------------------------------------------------------
module priority_message_dispatcher #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_AGENTS  = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pmd_pkg::FUNC_W-1:0]   in_func,
  input  logic [pmd_pkg::ID_W-1:0]     in_sender_id,
  input  logic [pmd_pkg::ID_W-1:0]     in_target_id,
  input  logic [pmd_pkg::REQ_W-1:0]    in_request_id,
  input  logic [pmd_pkg::PRIO_W-1:0]   in_priority_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pmd_pkg::STAT_W-1:0]   out_status,
  output logic [pmd_pkg::ID_W-1:0]     out_assigned_id,
  output logic [pmd_pkg::ID_W-1:0]     out_sender,
  output logic [pmd_pkg::ID_W-1:0]     out_target,
  output logic [pmd_pkg::REQ_W-1:0]    out_request,
  output logic [pmd_pkg::PRIO_W-1:0]   out_priority
);
  import pmd_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  pmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  pmd_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_AGENTS  (MAX_AGENTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dp_status       (dp_status),
    .in_sender_id    (in_sender_id),
    .in_target_id    (in_target_id),
    .in_request_id   (in_request_id),
    .in_priority_req (in_priority_req),
    .out_status      (out_status),
    .out_assigned_id (out_assigned_id),
    .out_sender      (out_sender),
    .out_target      (out_target),
    .out_request     (out_request),
    .out_priority    (out_priority)
  );

endmodule
